// File: design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/swstk_pkg.sv
package swstk_pkg;
  localparam int unsigned FeatureWordsDef = 65536;
  localparam int unsigned TopDepthDef = 16;

  localparam logic [2:0] ModeLoad   = 3'd0;
  localparam logic [2:0] ModeOpen   = 3'd1;
  localparam logic [2:0] ModeAdd    = 3'd2;
  localparam logic [2:0] ModeClose  = 3'd3;
  localparam logic [2:0] ModeReport = 3'd4;

  localparam logic RegOffset = 1'b0;
  localparam logic RegLimit  = 1'b1;

  typedef struct packed {
    logic load;
    logic open;
    logic add;
    logic close;
    logic emit;
    logic clear;
  } swstk_cmd_t;

  typedef struct packed {
    logic last;
    logic none;
  } swstk_sts_t;
endpackage

// File: design/swstk_ctrl.sv
module swstk_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2:0]             mode_i,
  input  swstk_pkg::swstk_sts_t  sts_i,
  output swstk_pkg::swstk_cmd_t  cmd_o,
  output logic                   busy_o
);
  import swstk_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAdd  = 4'b0010,
    StRep  = 4'b0100,
    StClr  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign take = start_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (take) begin
          case (mode_i)
            ModeLoad:   cmd_o.load = 1'b1;
            ModeOpen:   cmd_o.open = 1'b1;
            ModeAdd:    state_d = StAdd;
            ModeClose:  cmd_o.close = 1'b1;
            ModeReport: state_d = StRep;
            default:    ;
          endcase
        end
      end
      // table read data is registered, so the add is done in the following state
      StAdd: begin
        cmd_o.add = 1'b1;
        state_d = StIdle;
      end
      StRep: begin
        cmd_o.emit = 1'b1;
        if (sts_i.none || sts_i.last) state_d = StClr;
      end
      StClr: begin
        cmd_o.clear = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != StIdle);
endmodule

// File: design/swstk_dp.sv
module swstk_dp #(
  parameter int unsigned FEATURE_WORDS = swstk_pkg::FeatureWordsDef,
  parameter int unsigned TOP_DEPTH = swstk_pkg::TopDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swstk_pkg::swstk_cmd_t cmd_i,
  input  logic                  take_i,
  input  logic [15:0]           feature_index_i,
  input  logic signed [31:0]    weight_value_i,
  input  logic [31:0]           record_id_i,
  input  logic signed [31:0]    offset_i,
  input  logic [4:0]            limit_i,
  output swstk_pkg::swstk_sts_t sts_o,
  output logic                  result_valid_o,
  output logic [31:0]           ranked_id_o,
  output logic signed [31:0]    ranked_score_o,
  output logic                  last_of_run_o,
  output logic                  empty_report_o
);
  import swstk_pkg::*;

  localparam int unsigned AW = (FEATURE_WORDS > 1) ? $clog2(FEATURE_WORDS) : 1;
  localparam int unsigned CW = $clog2(TOP_DEPTH + 1);

  logic signed [31:0] mem [FEATURE_WORDS];
  logic signed [31:0] rd_q;
  logic               in_rng_q;
  logic               in_rng;

  assign in_rng = ({16'd0, feature_index_i} < 32'(FEATURE_WORDS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_rng) mem[feature_index_i[AW-1:0]] <= weight_value_i;
    rd_q <= mem[feature_index_i[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_rng_q <= 1'b0;
    else if (take_i) in_rng_q <= in_rng;
  end

  logic signed [31:0] score_q;
  logic [31:0]        rid_q;
  logic               open_q;
  logic signed [32:0] sum;
  logic signed [31:0] sat;

  assign sum = {score_q[31], score_q} + {rd_q[31], rd_q};
  always_comb begin
    if (sum[32] != sum[31]) sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else sat = sum[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      rid_q <= '0;
      open_q <= 1'b0;
    end else begin
      if (cmd_i.open) begin
        score_q <= offset_i;
        rid_q <= record_id_i;
        open_q <= 1'b1;
      end else if (cmd_i.add && open_q && in_rng_q) begin
        score_q <= sat;
      end else if (cmd_i.close) begin
        open_q <= 1'b0;
      end
    end
  end

  // sorted shift list, each cell decides locally on insert
  logic signed [31:0] bs_q [TOP_DEPTH];
  logic [31:0]        bi_q [TOP_DEPTH];
  logic [CW-1:0]      cnt_q;
  logic [TOP_DEPTH-1:0] ge;
  logic               ins;

  always_comb begin
    for (int i = 0; i < TOP_DEPTH; i++) ge[i] = (CW'(i) < cnt_q) && (bs_q[i] >= score_q);
  end
  assign ins = cmd_i.close && open_q;

  logic [CW-1:0] rp_q;
  logic [CW-1:0] n_rep;
  logic          lim_lt;
  assign lim_lt = (32'(limit_i) < 32'(cnt_q));
  assign n_rep = lim_lt ? CW'(limit_i) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rp_q <= '0;
      for (int i = 0; i < TOP_DEPTH; i++) begin
        bs_q[i] <= '0;
        bi_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
      rp_q <= '0;
    end else if (cmd_i.emit) begin
      rp_q <= rp_q + 1'b1;
    end else if (ins) begin
      for (int i = 0; i < TOP_DEPTH; i++) begin
        if (!ge[i]) begin
          if (i == 0 || ge[i-1]) begin
            bs_q[i] <= score_q;
            bi_q[i] <= rid_q;
          end else begin
            bs_q[i] <= bs_q[i-1];
            bi_q[i] <= bi_q[i-1];
          end
        end
      end
      if (!ge[TOP_DEPTH-1] && cnt_q < CW'(TOP_DEPTH)) cnt_q <= cnt_q + 1'b1;
    end
  end

  localparam int unsigned PW = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
  logic [PW-1:0] ridx;
  assign ridx = rp_q[PW-1:0];
  assign sts_o.none = (n_rep == '0);
  assign sts_o.last = (rp_q + 1'b1 == n_rep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ranked_id_o    <= sts_o.none ? '0 : bi_q[ridx];
      ranked_score_o <= sts_o.none ? '0 : bs_q[ridx];
      last_of_run_o  <= !sts_o.none && sts_o.last;
      empty_report_o <= sts_o.none;
    end
  end
endmodule

// File: design/sparse_weight_score_top_k.sv
// sparse feature scorer with running top-k list
// input channel: start_i with mode_i and its fields; taken when start_i is high
//   and busy_o is low
// load, open and close act in the idle state; add first reads the weight table
//   into a register, then does a saturating accumulate in the add state
// report: one result per cycle on result_valid_o, registered from the report state,
//   n results (n = min(limit, count), or one empty result), then the list is
//   cleared in the clear state; busy_o stays high throughout
// results are shown for exactly one cycle; the receiver cannot stall
// config: apb, offset at 0x0, limit at 0x4, pready always high
// reset clears score, list and count, offset to 0 and limit to 16; the weight table is not
//   cleared and an entry must be loaded before it is added
module sparse_weight_score_top_k #(
  parameter int unsigned FEATURE_WORDS = swstk_pkg::FeatureWordsDef,
  parameter int unsigned TOP_DEPTH = swstk_pkg::TopDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         mode_i,
  input  logic [15:0]        feature_index_i,
  input  logic signed [31:0] weight_value_i,
  input  logic [31:0]        record_id_i,
  output logic               result_valid_o,
  output logic [31:0]        ranked_id_o,
  output logic signed [31:0] ranked_score_o,
  output logic               last_of_run_o,
  output logic               empty_report_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import swstk_pkg::*;

  swstk_cmd_t cmd;
  swstk_sts_t sts;
  logic signed [31:0] offset_q;
  logic [4:0] limit_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      limit_q <= 5'd16;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegOffset) offset_q <= pwdata;
      else limit_q <= pwdata[4:0];
    end
  end

  always_comb begin
    if (paddr[2] == RegLimit) prdata = {27'd0, limit_q};
    else prdata = offset_q;
  end

  swstk_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .mode_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  swstk_dp #(.FEATURE_WORDS(FEATURE_WORDS), .TOP_DEPTH(TOP_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .take_i(start_i && !busy_o),
    .feature_index_i, .weight_value_i, .record_id_i,
    .offset_i(offset_q), .limit_i(limit_q), .sts_o(sts),
    .result_valid_o, .ranked_id_o, .ranked_score_o,
    .last_of_run_o, .empty_report_o
  );

`include "assert_macros.svh"
  `ASSERT_IMPL(a_one_kind, result_valid_o, !(last_of_run_o && empty_report_o))
  `ASSERT_NEXT(a_emit_busy, cmd.emit, busy_o)
  `ASSERT_IMPL(a_res_busy, result_valid_o, busy_o)
endmodule

// File: bench/sparse_weight_score_top_k_tb.sv
module sparse_weight_score_top_k_tb;
  import swstk_pkg::*;

  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        index;
    logic signed [31:0] weight;
    logic [31:0]        id;
  } request_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] score;
    logic               last;
    logic               empty;
  } rank_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         mode_i;
  logic [15:0]        feature_index_i;
  logic signed [31:0] weight_value_i;
  logic [31:0]        record_id_i;
  logic               result_valid_o;
  logic [31:0]        ranked_id_o;
  logic signed [31:0] ranked_score_o;
  logic               last_of_run_o;
  logic               empty_report_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  sparse_weight_score_top_k uut (.*);

  // predictor state
  logic signed [31:0] weights [int];
  logic signed [31:0] acc_score;
  logic [31:0]        acc_id;
  logic               acc_open;
  logic signed [31:0] top_score [16];
  logic [31:0]        top_id [16];
  int                 top_count;
  logic signed [31:0] cfg_offset;
  int                 cfg_limit;

  request_t pending_q[$];
  rank_t    ranking_q[$];
  int       errors;
  int       watchdog;
  int       gap;
  int       n_reports;
  int       n_ranks;
  bit       feed_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
    if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  task automatic rank_record(logic [31:0] id, logic signed [31:0] score);
    int pos;
    int last;
    pos = 0;
    while (pos < top_count && top_score[pos] >= score) pos++;
    if (pos >= 16) return;
    last = (top_count < 16) ? top_count : 15;
    for (int i = last; i > pos; i--) begin
      top_score[i] = top_score[i-1];
      top_id[i] = top_id[i-1];
    end
    top_score[pos] = score;
    top_id[pos] = id;
    if (top_count < 16) top_count++;
  endtask

  task automatic predict_ranking(request_t r);
    int n;
    rank_t e;
    case (r.mode)
      ModeLoad: weights[r.index] = r.weight;
      ModeOpen: begin
        acc_id = r.id;
        acc_score = cfg_offset;
        acc_open = 1'b1;
      end
      ModeAdd: if (acc_open) acc_score = sat_sum(acc_score, weights[r.index]);
      ModeClose: if (acc_open) begin
        rank_record(acc_id, acc_score);
        acc_open = 1'b0;
      end
      ModeReport: begin
        n = (cfg_limit < top_count) ? cfg_limit : top_count;
        n_reports++;
        if (n == 0) begin
          e = '0;
          e.empty = 1'b1;
          ranking_q.push_back(e);
        end else begin
          for (int k = 0; k < n; k++) begin
            e.id = top_id[k];
            e.score = top_score[k];
            e.last = (k == n - 1);
            e.empty = 1'b0;
            ranking_q.push_back(e);
          end
        end
        top_count = 0;
        for (int k = 0; k < 16; k++) begin
          top_score[k] = '0;
          top_id[k] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap = 0;
    end else begin
      if (start_i && !busy_o) begin
        predict_ranking(pending_q.pop_front());
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
      end
      if (!(start_i && busy_o)) begin
        if (gap > 0) begin
          gap--;
          start_i <= 1'b0;
        end else if (feed_on && pending_q.size() > 0) begin
          start_i <= 1'b1;
          mode_i <= pending_q[0].mode;
          feature_index_i <= pending_q[0].index;
          weight_value_i <= pending_q[0].weight;
          record_id_i <= pending_q[0].id;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      watchdog <= (result_valid_o || (start_i && !busy_o)) ? 0 : watchdog + 1;
      if (result_valid_o) begin
        n_ranks++;
        if (ranking_q.size() == 0) begin
          $display("%0t: unexpected result id %h score %h", $time, ranked_id_o,
                   ranked_score_o);
          errors++;
        end else begin
          rank_t e;
          e = ranking_q.pop_front();
          if (e.id !== ranked_id_o) begin
            $display("%0t: id exp %h got %h", $time, e.id, ranked_id_o);
            errors++;
          end
          if (e.score !== ranked_score_o) begin
            $display("%0t: score exp %h got %h", $time, e.score, ranked_score_o);
            errors++;
          end
          if (e.last !== last_of_run_o) begin
            $display("%0t: last exp %b got %b", $time, e.last, last_of_run_o);
            errors++;
          end
          if (e.empty !== empty_report_o) begin
            $display("%0t: empty exp %b got %b", $time, e.empty, empty_report_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (watchdog > 20000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) cfg_offset = data;
    else cfg_limit = int'(data[4:0]);
  endtask

  task automatic push(logic [2:0] m, logic [31:0] idx, logic [31:0] w,
                      logic [31:0] id);
    request_t r;
    r.mode = m;
    r.index = idx[15:0];
    r.weight = w;
    r.id = id;
    pending_q.push_back(r);
  endtask

  // run queued requests and wait for all ranks plus the clearing cycles
  task automatic drain();
    feed_on = 1'b1;
    while (pending_q.size() > 0 || ranking_q.size() > 0) @(posedge clk_i);
    feed_on = 1'b0;
    repeat (24) @(posedge clk_i);
  endtask

  // loaded indices, so an add never reads an unwritten entry
  logic [15:0] known[$];

  task automatic random_phase(int records);
    int nf;
    for (int r = 0; r < records; r++) begin
      if ($urandom_range(0, 3) == 0) begin
        logic [15:0] ix;
        ix = 16'($urandom);
        push(ModeLoad, 32'(ix), $urandom, $urandom);
        known.push_back(ix);
      end
      push(ModeOpen, $urandom, $urandom, $urandom);
      nf = $urandom_range(0, 4);
      for (int f = 0; f < nf; f++)
        push(ModeAdd, 32'(known[$urandom_range(0, known.size() - 1)]), $urandom, $urandom);
      case ($urandom_range(0, 9))
        0: push(ModeAdd, 32'(known[0]), $urandom, $urandom);
        1: push(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
        2: push(ModeReport, $urandom, $urandom, $urandom);
        default: ;
      endcase
      if ($urandom_range(0, 7) != 0) push(ModeClose, $urandom, $urandom, $urandom);
    end
    push(ModeReport, $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = '0;
    feature_index_i = '0;
    weight_value_i = '0;
    record_id_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    watchdog = 0;
    n_reports = 0;
    n_ranks = 0;
    feed_on = 1'b0;
    acc_score = '0;
    acc_id = '0;
    acc_open = 1'b0;
    top_count = 0;
    cfg_offset = '0;
    cfg_limit = 16;
    for (int k = 0; k < 16; k++) begin
      top_score[k] = '0;
      top_id[k] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, saturation, ignored requests, empty report
    push(ModeReport, 0, 0, 0);
    push(ModeAdd, 0, 0, 0);
    push(ModeClose, 0, 0, 0);
    push(ModeLoad, 32'h0000ffff, 32'h7fffffff, 0);
    push(ModeLoad, 32'h00000000, 32'h80000000, 32'hffffffff);
    push(ModeLoad, 32'h00005555, 32'h00010000, 0);
    known = '{16'hffff, 16'h0000, 16'h5555};
    push(ModeOpen, 0, 0, 32'hffffffff);
    push(ModeAdd, 32'h0000ffff, 0, 0);
    push(ModeAdd, 32'h0000ffff, 0, 0);
    push(ModeClose, 0, 0, 0);
    push(ModeOpen, 0, 0, 32'h00000000);
    push(ModeOpen, 0, 0, 32'h12345678);
    push(ModeAdd, 32'h00000000, 0, 0);
    push(ModeAdd, 32'h00000000, 0, 0);
    push(3'd5, 0, 0, 0);
    push(3'd7, 32'h0000ffff, 32'hffffffff, 32'hffffffff);
    push(ModeReport, 0, 0, 0);
    push(ModeClose, 0, 0, 0);
    push(ModeOpen, 0, 0, 32'haaaa5555);
    push(ModeAdd, 32'h00005555, 0, 0);
    push(ModeClose, 0, 0, 0);
    push(ModeReport, 0, 0, 0);
    drain();

    // sweep settings, extremes included; full list with ties and drop-off
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin apb_write(3'd0, 32'h80000000); apb_write(3'd4, 0); end
        1: begin apb_write(3'd0, 32'h7fffffff); apb_write(3'd4, 1); end
        2: begin apb_write(3'd0, $urandom); apb_write(3'd4, 16); end
        3: begin apb_write(3'd0, 0); apb_write(3'd4, 5); end
        4: begin apb_write(3'd0, $urandom); apb_write(3'd4, 31); end
        default: begin apb_write(3'd0, 32'h00010000); apb_write(3'd4, $urandom_range(0, 31)); end
      endcase
      if (ph == 3) begin
        // equal scores keep arrival order, more than sixteen forces drop-off
        for (int r = 0; r < 20; r++) begin
          push(ModeOpen, 0, 0, r);
          push(ModeClose, 0, 0, 0);
        end
        push(ModeReport, 0, 0, 0);
      end
      random_phase(9);
      drain();
    end

    $display("reports checked: %0d, ranked results: %0d, offset and limit swept",
             n_reports, n_ranks);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
